// ===== rtl/core/u3x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u3x_pkg
// Shared types and constants of the 3x oversampled 8N1 UART transceiver.
// ----------------------------------------------------------------------------
package u3x_pkg;

   // Frame and buffer geometry
   localparam int BUFFER_DEPTH  = 32;
   localparam int IDX_W         = $clog2(BUFFER_DEPTH);
   localparam int DATA_BITS     = 8;
   localparam int FRAME_BITS    = DATA_BITS + 2;
   localparam int TICKS_PER_BIT = 3;
   localparam int RX_START_WAIT = TICKS_PER_BIT + 1;

   // Counter widths
   localparam int TX_CNT_W  = 2;
   localparam int RX_CNT_W  = 3;
   localparam int BITS_W    = 4;
   localparam int POS_W     = 3;

   // Stream payload widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   // Request kinds
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_SEND  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_FLUSH = 2'd3
   } u3x_action_type;

   // Receiver phases, one-hot
   typedef enum logic [2:0] {
      RX_HUNT = 3'b001,
      RX_DATA = 3'b010,
      RX_STOP = 3'b100
   } u3x_rx_phase_type;

   // Status flags of one response, before the buffer data joins them
   typedef struct packed {
      logic tx_pin;
      logic tx_busy;
      logic send_refused;
      logic rx_byte_valid;
      logic data_available;
   } u3x_stat_type;

   // Ring buffer index advance with wrap
   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(BUFFER_DEPTH - 1)) begin
         return '0;
      end
      return idx + IDX_W'(1);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/uart_3x_oversampled_transceiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_3x_oversampled_transceiver
// 8N1 UART running at three ticks per bit with a receive ring buffer. Each
// request is a tick (advance transmitter, then receiver), a send, a read of
// the oldest received byte, or a buffer flush. One response per request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req      | in        | req_tvalid/tready  | tuser: action; tdata: rx_pin, tx_byte
//  rsp      | out       | rsp_tvalid/tready  | tdata: line, busy, refused, byte, flags
//  csr      | in        | csr_wen            | csr_wdata: rx_enable
//
//  One request per cycle while the output is not stalled. State updates at
//  the accept edge and the buffer read issues there; the registered RAM data
//  then joins the status flags of stage one in the output register.
//  Reset clears all control state at once; the buffer needs no clearing pass.
//  A stalled response holds the output register; the stage before it still
//  takes one request, then req_tready drops until the output drains.
// ----------------------------------------------------------------------------
module uart_3x_oversampled_transceiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: tuser[1:0] action; tdata[0] rx_pin, [8:1] tx_byte, [15:9] zero
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [u3x_pkg::REQ_USER_W-1:0]  req_tuser,
   input  wire logic [u3x_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response: tdata[0] tx_pin, [1] tx_busy, [2] send_refused, [10:3] rx_byte,
   //           [11] rx_byte_valid, [12] data_available, [15:13] zero
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [u3x_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration: rx_enable
   input  wire logic                            csr_wen,
   input  wire logic                            csr_wdata
);
   import u3x_pkg::*;

   // Handshake and pipeline control
   logic           accept;
   logic           advance;
   u3x_action_type action;
   logic           rx_pin;
   logic [7:0]     tx_byte;

   // Transmitter state
   logic [FRAME_BITS-1:0] tx_shift_ff,      tx_shift_in;
   logic [TX_CNT_W-1:0]   tx_tick_count_ff, tx_tick_count_in;
   logic [BITS_W-1:0]     tx_bits_left_ff,  tx_bits_left_in;
   logic                  tx_active_ff,     tx_active_in;
   logic                  tx_level_ff,      tx_level_in;
   logic [TX_CNT_W-1:0]   tx_t;

   // Receiver state
   u3x_rx_phase_type      rx_phase_ff,      rx_phase_in;
   logic [RX_CNT_W-1:0]   rx_tick_count_ff, rx_tick_count_in;
   logic [BITS_W-1:0]     rx_bits_left_ff,  rx_bits_left_in;
   logic [DATA_BITS-1:0]  rx_shift_ff,      rx_shift_in;
   logic [RX_CNT_W-1:0]   rx_t;
   logic [POS_W-1:0]      rx_pos;
   logic                  rx_enable_ff;

   // Ring buffer control
   logic [IDX_W-1:0]      write_index_ff,   write_index_in;
   logic [IDX_W-1:0]      read_index_ff,    read_index_in;
   logic [IDX_W-1:0]      wi_next;
   logic                  not_empty_ff,     not_empty_in;
   logic                  store;
   logic                  buf_read;
   logic [7:0]            ram_rd_data;

   // Per-request flags
   logic                  refused;
   logic                  rvalid;

   // Pipeline registers
   logic                  s1_valid_ff, s1_valid_in;
   u3x_stat_type          s1_stat_ff;
   logic                  out_valid_ff, out_valid_in;
   u3x_stat_type          out_stat_ff;
   logic [7:0]            out_byte_ff;

   assign action  = u3x_action_type'(req_tuser);
   assign rx_pin  = req_tdata[0];
   assign tx_byte = req_tdata[8:1];

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // Next state for one request
   always_comb begin
      tx_shift_in      = tx_shift_ff;
      tx_tick_count_in = tx_tick_count_ff;
      tx_bits_left_in  = tx_bits_left_ff;
      tx_active_in     = tx_active_ff;
      tx_level_in      = tx_level_ff;
      rx_phase_in      = rx_phase_ff;
      rx_tick_count_in = rx_tick_count_ff;
      rx_bits_left_in  = rx_bits_left_ff;
      rx_shift_in      = rx_shift_ff;
      write_index_in   = write_index_ff;
      read_index_in    = read_index_ff;
      not_empty_in     = not_empty_ff;
      store            = 1'b0;
      buf_read         = 1'b0;
      refused          = 1'b0;
      rvalid           = 1'b0;
      tx_t             = tx_tick_count_ff - TX_CNT_W'(1);
      rx_t             = rx_tick_count_ff - RX_CNT_W'(1);
      rx_pos           = POS_W'(BITS_W'(DATA_BITS) - rx_bits_left_ff);
      wi_next          = next_index(write_index_ff);

      case (action)
         ACT_TICK: begin
            // transmitter: one bit every three ticks
            if (tx_active_ff) begin
               if (tx_t == '0) begin
                  tx_level_in      = tx_shift_ff[0];
                  tx_shift_in      = tx_shift_ff >> 1;
                  tx_tick_count_in = TX_CNT_W'(TICKS_PER_BIT);
                  tx_bits_left_in  = tx_bits_left_ff - BITS_W'(1);
                  if (tx_bits_left_in == '0) begin
                     tx_active_in = 1'b0;
                  end
               end else begin
                  tx_tick_count_in = tx_t;
               end
            end
            // receiver
            if (rx_enable_ff) begin
               case (rx_phase_ff)
                  RX_STOP: begin
                     rx_tick_count_in = rx_t;
                     if (rx_t == '0) begin
                        rx_phase_in = RX_HUNT;
                        store       = 1'b1;
                     end
                  end
                  RX_DATA: begin
                     if (rx_t == '0) begin
                        rx_tick_count_in = RX_CNT_W'(TICKS_PER_BIT);
                        rx_shift_in[rx_pos] = rx_shift_ff[rx_pos] | rx_pin;
                        rx_bits_left_in = rx_bits_left_ff - BITS_W'(1);
                        if (rx_bits_left_in == '0) begin
                           rx_phase_in = RX_STOP;
                        end
                     end else begin
                        rx_tick_count_in = rx_t;
                     end
                  end
                  default: begin
                     // hunting for a start bit
                     if (!rx_pin) begin
                        rx_phase_in      = RX_DATA;
                        rx_shift_in      = '0;
                        rx_tick_count_in = RX_CNT_W'(RX_START_WAIT);
                        rx_bits_left_in  = BITS_W'(DATA_BITS);
                     end
                  end
               endcase
            end
            // received byte into the ring, oldest dropped on overflow
            if (store) begin
               write_index_in = wi_next;
               if (not_empty_ff && wi_next == read_index_ff) begin
                  read_index_in = next_index(read_index_ff);
               end
               not_empty_in = 1'b1;
            end
         end
         ACT_SEND: begin
            if (tx_active_ff) begin
               refused = 1'b1;
            end else begin
               tx_tick_count_in = TX_CNT_W'(TICKS_PER_BIT);
               tx_bits_left_in  = BITS_W'(FRAME_BITS);
               tx_shift_in      = {1'b1, tx_byte[DATA_BITS-1:0], 1'b0};
               tx_active_in     = 1'b1;
            end
         end
         ACT_READ: begin
            if (not_empty_ff) begin
               buf_read      = 1'b1;
               rvalid        = 1'b1;
               read_index_in = next_index(read_index_ff);
               if (read_index_in == write_index_ff) begin
                  not_empty_in = 1'b0;
               end
            end
         end
         default: begin
            // flush
            write_index_in = '0;
            read_index_in  = '0;
            not_empty_in   = 1'b0;
         end
      endcase
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff      <= '0;
         tx_tick_count_ff <= '0;
         tx_bits_left_ff  <= '0;
         tx_active_ff     <= 1'b0;
         tx_level_ff      <= 1'b1;
         rx_phase_ff      <= RX_HUNT;
         rx_tick_count_ff <= '0;
         rx_bits_left_ff  <= '0;
         rx_shift_ff      <= '0;
         write_index_ff   <= '0;
         read_index_ff    <= '0;
         not_empty_ff     <= 1'b0;
      end else if (accept) begin
         tx_shift_ff      <= tx_shift_in;
         tx_tick_count_ff <= tx_tick_count_in;
         tx_bits_left_ff  <= tx_bits_left_in;
         tx_active_ff     <= tx_active_in;
         tx_level_ff      <= tx_level_in;
         rx_phase_ff      <= rx_phase_in;
         rx_tick_count_ff <= rx_tick_count_in;
         rx_bits_left_ff  <= rx_bits_left_in;
         rx_shift_ff      <= rx_shift_in;
         write_index_ff   <= write_index_in;
         read_index_ff    <= read_index_in;
         not_empty_ff     <= not_empty_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff <= 1'b1;
      end else if (csr_wen) begin
         rx_enable_ff <= csr_wdata;
      end
   end

   // Receive buffer
   u3x_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (BUFFER_DEPTH)
   ) u_rx_store (
      .clock   (clock),
      .wr_en   (accept && store),
      .wr_addr (write_index_ff),
      .wr_data (rx_shift_ff),
      .rd_en   (accept && buf_read),
      .rd_addr (read_index_ff),
      .rd_data (ram_rd_data)
   );

   // Stage one: flags of the accepted request, waits for the buffer data
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff.tx_pin         <= tx_level_in;
         s1_stat_ff.tx_busy        <= tx_active_in;
         s1_stat_ff.send_refused   <= refused;
         s1_stat_ff.rx_byte_valid  <= rvalid;
         s1_stat_ff.data_available <= not_empty_in;
      end
   end

   // Output register
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_stat_ff <= s1_stat_ff;
         out_byte_ff <= s1_stat_ff.rx_byte_valid ? ram_rd_data : 8'd0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_stat_ff.data_available,
                        out_stat_ff.rx_byte_valid,
                        out_byte_ff,
                        out_stat_ff.send_refused,
                        out_stat_ff.tx_busy,
                        out_stat_ff.tx_pin};

   // Checks
   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      !not_empty_ff |-> read_index_ff == write_index_ff)
      else $error("buffer marked empty with differing indices");

   a_tx_idle_bits: assert property (@(posedge clock) disable iff (reset)
      !tx_active_ff |-> tx_bits_left_ff == '0)
      else $error("transmitter idle with frame bits left");

   a_tx_cnt: assert property (@(posedge clock) disable iff (reset)
      tx_active_ff |-> tx_tick_count_ff != '0)
      else $error("transmitter tick counter zero while active");

endmodule
`default_nettype wire

// ===== rtl/core/u3x_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u3x_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module u3x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== dv/tb_uart_3x_oversampled_transceiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_3x_oversampled_transceiver
// Self-checking bench for the 3x oversampled 8N1 UART transceiver. A short
// table of directed requests runs first, then random phases: receive frames
// with random content and host sends, reads and flushes mixed in, broken
// frames and noise, a phase with the receiver disabled, and a run of
// back-to-back frames with no reads and no idling. Each accepted request is
// run through a cycle-free model of the transceiver, and each response is
// compared field by field with the oldest expected response.
// ----------------------------------------------------------------------------
module tb_uart_3x_oversampled_transceiver;
   import u3x_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 8;     // stage one and output register, plus margin
   localparam int HOLD_CYCLES    = 150;   // long response-sink hold-off
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 50;
   localparam int DIR_ROWS       = 10;
   localparam int QUIET_FRAMES   = 3;

   // Response word, lowest bit last
   typedef struct packed {
      logic [2:0] pad;
      logic       avail;
      logic       valid;
      logic [7:0] rbyte;
      logic       refused;
      logic       busy;
      logic       line;
   } rsp_word_type;

   // One request with an optional hand-typed response
   typedef struct packed {
      u3x_action_type act;
      logic           pin;
      logic [7:0]     data;
      logic           typed;
      rsp_word_type   want;
   } req_item_type;

   // Directed table row: a request repeated reps times
   typedef struct packed {
      logic [4:0]     reps;
      u3x_action_type act;
      logic           pin;
      logic [7:0]     data;
      logic           typed;
      rsp_word_type   want;
   } dir_row_type;

   localparam rsp_word_type RSP_IDLE    = 16'h0001;  // line high, nothing else
   localparam rsp_word_type RSP_BUSY    = 16'h0003;  // frame queued, line high
   localparam rsp_word_type RSP_REFUSED = 16'h0007;  // send refused while busy

   // DUT ports
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_USER_W-1:0] req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen;
   logic                  csr_wdata;

   // Stimulus and scoreboard
   req_item_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   req_item_type cur_item;
   dir_row_type  dir_tab [DIR_ROWS];
   bit        req_fired;
   bit        quiet;
   bit        hold_arm;
   int        queued_items;
   int        mismatch_count;
   int        rsp_count;
   int        req_count;
   int        cfg_writes;
   int        idle_cycles;

   // Transceiver model state
   logic [9:0]       tx_shift;
   logic [1:0]       tx_ticks;
   logic [3:0]       tx_left;
   logic             tx_on;
   logic             tx_line;
   u3x_rx_phase_type rx_phase;
   logic [2:0]       rx_ticks;
   logic [3:0]       rx_left;
   logic [7:0]       rx_sr;
   logic [7:0]       rx_mem [BUFFER_DEPTH];
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             have_data;
   logic             rx_en;
   int               stored_bytes;
   int               overflows;
   int               refused_sends;
   int               bytes_read;

   uart_3x_oversampled_transceiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // Ring index advance with wrap at the buffer depth
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   // Apply one request to the model, return the response it gives
   function automatic rsp_word_type uart_advance(input req_item_type r);
      rsp_word_type res;
      logic [1:0] tt;
      logic [2:0] rt;
      logic [2:0] pos;
      res = '0;
      case (r.act)
         ACT_TICK: begin
            // transmitter first: one bit every three ticks
            if (tx_on) begin
               tt = tx_ticks - 2'd1;
               if (tt == 2'd0) begin
                  tx_line  = tx_shift[0];
                  tx_shift = tx_shift >> 1;
                  tt       = 2'(TICKS_PER_BIT);
                  tx_left  = tx_left - 4'd1;
                  if (tx_left == 4'd0) begin
                     tx_on = 1'b0;
                  end
               end
               tx_ticks = tt;
            end
            // receiver, frozen while disabled
            if (rx_en) begin
               case (rx_phase)
                  RX_STOP: begin
                     rx_ticks = rx_ticks - 3'd1;
                     if (rx_ticks == 3'd0) begin
                        rx_phase       = RX_HUNT;
                        rx_mem[wr_idx] = rx_sr;
                        wr_idx         = ring_next(wr_idx);
                        if (have_data && wr_idx == rd_idx) begin
                           rd_idx = ring_next(rd_idx);
                           overflows++;
                        end
                        have_data = 1'b1;
                        stored_bytes++;
                     end
                  end
                  RX_DATA: begin
                     rt = rx_ticks - 3'd1;
                     if (rt == 3'd0) begin
                        pos = 3'(DATA_BITS - int'(rx_left));
                        rt  = 3'(TICKS_PER_BIT);
                        if (r.pin) begin
                           rx_sr[pos] = 1'b1;
                        end
                        rx_left = rx_left - 4'd1;
                        if (rx_left == 4'd0) begin
                           rx_phase = RX_STOP;
                        end
                     end
                     rx_ticks = rt;
                  end
                  default: begin
                     // hunting: low level starts a frame
                     if (!r.pin) begin
                        rx_phase = RX_DATA;
                        rx_sr    = '0;
                        rx_ticks = 3'(RX_START_WAIT);
                        rx_left  = 4'(DATA_BITS);
                     end
                  end
               endcase
            end
         end
         ACT_SEND: begin
            if (tx_on) begin
               res.refused = 1'b1;
               refused_sends++;
            end else begin
               tx_ticks = 2'(TICKS_PER_BIT);
               tx_left  = 4'(FRAME_BITS);
               tx_shift = {1'b1, r.data, 1'b0};
               tx_on    = 1'b1;
            end
         end
         ACT_READ: begin
            if (have_data) begin
               res.rbyte = rx_mem[rd_idx];
               res.valid = 1'b1;
               rd_idx    = ring_next(rd_idx);
               if (rd_idx == wr_idx) begin
                  have_data = 1'b0;
               end
               bytes_read++;
            end
         end
         default: begin
            wr_idx    = '0;
            rd_idx    = '0;
            have_data = 1'b0;
         end
      endcase
      res.line  = tx_line;
      res.busy  = tx_on;
      res.avail = have_data;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("MISMATCH response %0d: %s", rsp_count, msg);
      end
      mismatch_count++;
   endtask

   task automatic push_item(input u3x_action_type act, input logic pin,
                            input logic [7:0] data);
      req_item_type it;
      it       = '0;
      it.act   = act;
      it.pin   = pin;
      it.data  = data;
      pending_reqs.push_back(it);
      queued_items++;
   endtask

   // Well-formed receive frame on rx_pin, host requests mixed in at random
   task automatic push_frame(input logic [7:0] value, input bit host_reads);
      int   b;
      int   k;
      logic lvl;
      for (b = 0; b < FRAME_BITS; b++) begin
         lvl = (b == 0) ? 1'b0 : (b == FRAME_BITS - 1) ? 1'b1 : value[b-1];
         for (k = 0; k < TICKS_PER_BIT; k++) begin
            if ($urandom_range(0, 99) < 8) begin
               push_item((host_reads && $urandom_range(0, 2) == 0) ? ACT_READ : ACT_SEND,
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            push_item(ACT_TICK, lvl, 8'($urandom_range(0, 255)));
         end
      end
      for (b = $urandom_range(0, 2); b > 0; b--) begin
         push_item(ACT_TICK, 1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   // Random mix of frames, reads, broken frames, sends on an idle line, flushes, noise
   task automatic push_mixed(input int budget);
      int stop_at;
      int r;
      int n;
      stop_at = queued_items + budget;
      while (queued_items < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            push_frame(8'($urandom_range(0, 255)), 1'b1);
         end else if (r < 65) begin
            for (n = $urandom_range(1, 4); n > 0; n--) begin
               push_item(ACT_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end else if (r < 75) begin
            // start bit followed by garbage of random length
            push_item(ACT_TICK, 1'b0, 8'($urandom_range(0, 255)));
            for (n = $urandom_range(2, 20); n > 0; n--) begin
               push_item(ACT_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end else if (r < 85) begin
            push_item(ACT_SEND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            for (n = $urandom_range(1, 8); n > 0; n--) begin
               push_item(ACT_TICK, 1'b1, 8'($urandom_range(0, 255)));
            end
         end else if (r < 90) begin
            push_item(ACT_FLUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            for (n = $urandom_range(1, 6); n > 0; n--) begin
               push_item(u3x_action_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Wait until every request is accepted and every response has come
   task automatic wait_drained();
      while (!(pending_reqs.size() == 0 && (!req_tvalid || req_fired)
               && expected_rsps.size() == 0)) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
   endtask

   // Register write while idle
   task automatic write_csr(input logic value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      rx_en      = value;
      cfg_writes++;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Request driver: changes on the falling edge
   initial begin
      req_item_type nxt;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      cur_item   = '0;
      forever begin
         @(negedge clock);
         if (reset) begin
            req_tvalid <= 1'b0;
         end else if (req_tvalid && !req_fired) begin
            // hold the offered request
         end else if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
            nxt         = pending_reqs.pop_front();
            cur_item    = nxt;
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.act;
            req_tdata  <= REQ_DATA_W'({nxt.data, nxt.pin});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls plus one long hold-off
   initial begin
      int hold_left;
      bit hold_used;
      hold_left  = 0;
      hold_used  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_arm && !hold_used) begin
            hold_used   = 1'b1;
            hold_left   = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || $urandom_range(0, 99) >= 10;
         end
      end
   end

   // Monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      rsp_word_type predicted;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response 0x%04h", got));
            end else begin
               want = expected_rsps.pop_front();
               if (got.line !== want.line)
                  report_mismatch($sformatf("tx_pin %b want %b", got.line, want.line));
               if (got.busy !== want.busy)
                  report_mismatch($sformatf("tx_busy %b want %b", got.busy, want.busy));
               if (got.refused !== want.refused)
                  report_mismatch($sformatf("send_refused %b want %b",
                                            got.refused, want.refused));
               if (got.rbyte !== want.rbyte)
                  report_mismatch($sformatf("rx_byte 0x%02h want 0x%02h",
                                            got.rbyte, want.rbyte));
               if (got.valid !== want.valid)
                  report_mismatch($sformatf("rx_byte_valid %b want %b",
                                            got.valid, want.valid));
               if (got.avail !== want.avail)
                  report_mismatch($sformatf("data_available %b want %b",
                                            got.avail, want.avail));
               if (got.pad !== want.pad)
                  report_mismatch($sformatf("padding %b want %b", got.pad, want.pad));
            end
            rsp_count++;
         end
         req_fired = req_tvalid && req_tready;
         if (req_fired) begin
            predicted = uart_advance(cur_item);
            expected_rsps.push_back(cur_item.typed ? cur_item.want : predicted);
            req_count++;
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset && !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         idle_cycles++;
      end else begin
         idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Main sequence
   initial begin
      req_item_type item;
      int        i;
      int        k;
      reset          = 1'b1;
      csr_wen        = 1'b0;
      csr_wdata      = 1'b0;
      quiet          = 1'b0;
      hold_arm       = 1'b0;
      queued_items   = 0;
      mismatch_count = 0;
      rsp_count      = 0;
      req_count      = 0;
      cfg_writes     = 0;
      idle_cycles    = 0;
      stored_bytes   = 0;
      overflows      = 0;
      refused_sends  = 0;
      bytes_read     = 0;

      // model state after reset
      tx_shift  = '0;
      tx_ticks  = '0;
      tx_left   = '0;
      tx_on     = 1'b0;
      tx_line   = 1'b1;
      rx_phase  = RX_HUNT;
      rx_ticks  = '0;
      rx_left   = '0;
      rx_sr     = '0;
      wr_idx    = '0;
      rd_idx    = '0;
      have_data = 1'b0;
      rx_en     = 1'b1;
      for (i = 0; i < BUFFER_DEPTH; i++) begin
         rx_mem[i] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: reps, action, rx_pin, tx_byte, typed, response
      dir_tab[0] = '{5'd1,  ACT_READ,  1'b0, 8'hA5, 1'b1, RSP_IDLE};    // read while empty
      dir_tab[1] = '{5'd1,  ACT_FLUSH, 1'b1, 8'h5A, 1'b1, RSP_IDLE};    // flush when empty
      dir_tab[2] = '{5'd1,  ACT_TICK,  1'b1, 8'hFF, 1'b1, RSP_IDLE};    // idle line
      dir_tab[3] = '{5'd1,  ACT_SEND,  1'b0, 8'h00, 1'b1, RSP_BUSY};    // send all zeros
      dir_tab[4] = '{5'd1,  ACT_SEND,  1'b1, 8'hFF, 1'b1, RSP_REFUSED}; // send while busy
      dir_tab[5] = '{5'd1,  ACT_READ,  1'b1, 8'h00, 1'b1, RSP_BUSY};    // empty read, busy
      dir_tab[6] = '{5'd3,  ACT_TICK,  1'b1, 8'h00, 1'b0, RSP_IDLE};    // start bit goes out
      dir_tab[7] = '{5'd13, ACT_TICK,  1'b0, 8'hFF, 1'b0, RSP_IDLE};    // rx start, zero bits
      dir_tab[8] = '{5'd1,  ACT_READ,  1'b0, 8'h00, 1'b0, RSP_IDLE};
      dir_tab[9] = '{5'd1,  ACT_FLUSH, 1'b0, 8'hFF, 1'b0, RSP_IDLE};
      for (i = 0; i < DIR_ROWS; i++) begin
         for (k = 0; k < int'(dir_tab[i].reps); k++) begin
            item.act   = dir_tab[i].act;
            item.pin   = dir_tab[i].pin;
            item.data  = dir_tab[i].data;
            item.typed = dir_tab[i].typed;
            item.want  = dir_tab[i].want;
            pending_reqs.push_back(item);
            queued_items++;
         end
      end
      wait_drained();

      // Receiver disabled: line activity must leave it frozen
      write_csr(1'b0);
      push_mixed(60);
      wait_drained();

      // Receiver on, random mix; sink holds off at the start to fill the block
      write_csr(1'b1);
      hold_arm = 1'b1;
      push_mixed(140);
      wait_drained();

      // Back-to-back frames, no reads, no idling, then drain the buffer
      quiet = 1'b1;
      for (i = 0; i < QUIET_FRAMES; i++) begin
         push_frame(8'($urandom_range(0, 255)), 1'b0);
      end
      for (i = 0; i < QUIET_FRAMES + 2; i++) begin
         push_item(ACT_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      wait_drained();
      quiet = 1'b0;

      // Closing random mix
      push_mixed(50);
      wait_drained();

      if (expected_rsps.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
      end
      $display("Covered %0d requests and %0d responses; receiver stored %0d bytes, %0d lost",
               req_count, rsp_count, stored_bytes, overflows);
      $display("  to overflow; %0d sends refused, %0d bytes read, %0d register writes",
               refused_sends, bytes_read, cfg_writes);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
